// ===== rtl/kwm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared constants and types of the multiway run merger: item kinds, head
// states and the structs that travel between the top level and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package kwm_pkg;

  localparam int TAPES_DEF = 4;

  localparam int KindW = 2;
  localparam int TapeW = 2;
  localparam int KeyW  = 32;
  localparam int IdW   = 32;
  localparam int NextW = 3;

  localparam logic [KindW-1:0] KIND_RECORD  = 2'd0;
  localparam logic [KindW-1:0] KIND_RUN_END = 2'd1;
  localparam logic [KindW-1:0] KIND_EXHAUST = 2'd2;

  localparam logic [1:0] HS_PENDING   = 2'd0;
  localparam logic [1:0] HS_ACTIVE    = 2'd1;
  localparam logic [1:0] HS_RUN_END   = 2'd2;
  localparam logic [1:0] HS_EXHAUSTED = 2'd3;

  typedef struct packed {
    logic [KindW-1:0]       kind;
    logic signed [KeyW-1:0] key;
    logic [IdW-1:0]         id;
  } head_wr_t;

  typedef struct packed {
    logic                   found;
    logic                   all_exh;
    logic signed [KeyW-1:0] key;
    logic [IdW-1:0]         id;
  } cand_t;

endpackage

`default_nettype wire

// ===== rtl/kwm_cell.sv =====
// ----------------------------------------------------------------------------
// kwm_cell
// One tape head of the merger. It holds the head's state, key and id, and
// folds its head into the candidate that passes through it on its way down
// the chain, one cell per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_cell #(
  parameter int TAPES    = kwm_pkg::TAPES_DEF,
  parameter int CELL_IDX = 0,
  localparam int IdxW    = (TAPES > 1) ? $clog2(TAPES) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire kwm_pkg::head_wr_t wr,
  input  wire logic             clr,
  input  wire logic             cand_vld_i,
  input  wire kwm_pkg::cand_t   cand_i,
  input  wire logic [IdxW-1:0]  cand_idx_i,
  output logic                  cand_vld_o,
  output kwm_pkg::cand_t        cand_o,
  output logic [IdxW-1:0]       cand_idx_o,
  output logic                  pending_o
);

  logic [1:0]                      status_r;
  logic signed [kwm_pkg::KeyW-1:0] key_r;
  logic [kwm_pkg::IdW-1:0]         id_r;
  logic                            vld_r;
  kwm_pkg::cand_t                  cand_r;
  logic [IdxW-1:0]                 idx_r;
  kwm_pkg::cand_t                  cand_nxt;
  logic [IdxW-1:0]                 idx_nxt;
  logic                            active;
  logic                            take;

  assign active = (status_r == kwm_pkg::HS_ACTIVE);
  assign take   = active && (!cand_i.found || (key_r <= cand_i.key));

  always_comb begin
    cand_nxt.found   = cand_i.found | active;
    cand_nxt.all_exh = cand_i.all_exh & (status_r == kwm_pkg::HS_EXHAUSTED);
    cand_nxt.key     = take ? key_r : cand_i.key;
    cand_nxt.id      = take ? id_r : cand_i.id;
    idx_nxt          = take ? IdxW'(CELL_IDX) : cand_idx_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= kwm_pkg::HS_PENDING;
      vld_r    <= 1'b0;
    end else begin
      vld_r <= cand_vld_i;
      if (clr) begin
        status_r <= kwm_pkg::HS_PENDING;
      end else if (wr_en && (status_r == kwm_pkg::HS_PENDING)) begin
        case (wr.kind)
          kwm_pkg::KIND_RECORD:  status_r <= kwm_pkg::HS_ACTIVE;
          kwm_pkg::KIND_RUN_END: status_r <= kwm_pkg::HS_RUN_END;
          kwm_pkg::KIND_EXHAUST: status_r <= kwm_pkg::HS_EXHAUSTED;
          default:               status_r <= status_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (status_r == kwm_pkg::HS_PENDING) && (wr.kind == kwm_pkg::KIND_RECORD)) begin
      key_r <= wr.key;
      id_r  <= wr.id;
    end
    cand_r <= cand_nxt;
    idx_r  <= idx_nxt;
  end

  assign cand_vld_o = vld_r;
  assign cand_o     = cand_r;
  assign cand_idx_o = idx_r;
  assign pending_o  = (status_r == kwm_pkg::HS_PENDING);

endmodule

`default_nettype wire

// ===== rtl/kway_run_merger.sv =====
// An item whose tape head leaves some head still waiting for input passes
// through the transfer and then the pending check. An item that completes
// the set of heads passes through the check, the chain of head cells (one
// cell per tape) that the selection candidate moves through, a capture into
// the result register and the load of the output register. Input transfers
// stall while an item is being worked on; the output register lets a
// finished result wait for its transfer while the next item is taken in.
// ----------------------------------------------------------------------------
// kway_run_merger
// Balanced multiway merge of sorted runs. Keeps one head per tape, emits the
// smallest signed key (ties to the highest tape), run-end markers and the
// pass-done indication, and names the tape to feed next.
// ----------------------------------------------------------------------------
`default_nettype none

module kway_run_merger #(
  parameter int TAPES = kwm_pkg::TAPES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [kwm_pkg::KindW-1:0]     in_kind,
  input  wire logic [kwm_pkg::TapeW-1:0]     in_tape,
  input  wire logic signed [kwm_pkg::KeyW-1:0] in_sort_key,
  input  wire logic [kwm_pkg::IdW-1:0]       in_record_id,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [kwm_pkg::KeyW-1:0]    out_key,
  output logic [kwm_pkg::IdW-1:0]            out_id,
  output logic [kwm_pkg::TapeW-1:0]          out_source_tape,
  output logic                               out_run_end,
  output logic                               out_pass_done,
  output logic [kwm_pkg::NextW-1:0]          out_next_tape
);

  localparam int IdxW = (TAPES > 1) ? $clog2(TAPES) : 1;
  localparam logic [kwm_pkg::NextW-1:0] AllCode = kwm_pkg::NextW'(TAPES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]        state_r;
  logic [1:0]        state_nxt;
  logic              in_xfer;
  logic              launch;
  logic              load_out;
  logic              any_pend;
  logic [TAPES-1:0]  pend;
  logic [TAPES-1:0]  stage_vld;
  logic              chain_vld [0:TAPES];
  kwm_pkg::cand_t    chain     [0:TAPES];
  logic [IdxW-1:0]   chain_idx [0:TAPES];
  kwm_pkg::head_wr_t wr;
  kwm_pkg::cand_t    res_r;
  logic [IdxW-1:0]   res_idx_r;
  logic [31:0]       res_idx_ext;

  logic                            out_valid_r;
  logic signed [kwm_pkg::KeyW-1:0] out_key_r;
  logic [kwm_pkg::IdW-1:0]         out_id_r;
  logic [kwm_pkg::TapeW-1:0]       out_source_tape_r;
  logic                            out_run_end_r;
  logic                            out_pass_done_r;
  logic [kwm_pkg::NextW-1:0]       out_next_tape_r;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign any_pend = |pend;
  assign launch   = (state_r == ST_CHECK) && !any_pend;
  assign load_out = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  assign wr.kind = in_kind;
  assign wr.key  = in_sort_key;
  assign wr.id   = in_record_id;

  assign chain_vld[0]       = launch;
  assign chain[0].found     = 1'b0;
  assign chain[0].all_exh   = 1'b1;
  assign chain[0].key       = '0;
  assign chain[0].id        = '0;
  assign chain_idx[0]       = '0;

  for (genvar i = 0; i < TAPES; i++) begin : g_cell
    logic cell_wr_en;
    logic cell_clr;

    assign cell_wr_en = in_xfer && (32'(in_tape) == i);
    assign cell_clr   = load_out && (!res_r.found || (res_idx_r == IdxW'(i)));

    kwm_cell #(
      .TAPES    (TAPES),
      .CELL_IDX (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .wr_en      (cell_wr_en),
      .wr         (wr),
      .clr        (cell_clr),
      .cand_vld_i (chain_vld[i]),
      .cand_i     (chain[i]),
      .cand_idx_i (chain_idx[i]),
      .cand_vld_o (chain_vld[i+1]),
      .cand_o     (chain[i+1]),
      .cand_idx_o (chain_idx[i+1]),
      .pending_o  (pend[i])
    );

    assign stage_vld[i] = chain_vld[i+1];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = any_pend ? ST_IDLE : ST_SCAN;
      ST_SCAN:  if (chain_vld[TAPES]) state_nxt = ST_EMIT;
      ST_EMIT:  if (load_out) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign res_idx_ext = 32'(res_idx_r);

  always_ff @(posedge clk) begin
    if ((state_r == ST_SCAN) && chain_vld[TAPES]) begin
      res_r     <= chain[TAPES];
      res_idx_r <= chain_idx[TAPES];
    end
    if (load_out) begin
      out_key_r         <= res_r.found ? res_r.key : '0;
      out_id_r          <= res_r.found ? res_r.id : '0;
      out_source_tape_r <= res_r.found ? res_idx_ext[kwm_pkg::TapeW-1:0] : '0;
      out_run_end_r     <= !res_r.found && !res_r.all_exh;
      out_pass_done_r   <= !res_r.found && res_r.all_exh;
      out_next_tape_r   <= res_r.found ? res_idx_ext[kwm_pkg::NextW-1:0] : AllCode;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_key         = out_key_r;
  assign out_id          = out_id_r;
  assign out_source_tape = out_source_tape_r;
  assign out_run_end     = out_run_end_r;
  assign out_pass_done   = out_pass_done_r;
  assign out_next_tape   = out_next_tape_r;

  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_CHECK))
    else $error("accepted item did not move to the pending check");

  a_pending_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_CHECK) && any_pend) |=> (state_r == ST_IDLE))
    else $error("pending head did not return the block to idle");

  a_one_candidate: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(stage_vld))
    else $error("more than one candidate in the cell chain");

  a_chain_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chain_vld[TAPES] |-> (state_r == ST_SCAN))
    else $error("candidate left the chain outside the scan");

  a_record_result: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && res_r.found) |=> (out_valid && !out_run_end && !out_pass_done))
    else $error("record result carries a marker flag");

endmodule

`default_nettype wire
